>>> rtl/sprpg_pkg.sv
package sprpg_pkg;

	// parameter defaults
	localparam int POS_BITS_DEF  = 32;
	localparam int RATE_BITS_DEF = 16;

	// field and port widths
	localparam int CMD_W       = 3;
	localparam int STEPS_W     = 32;
	localparam int RATE_W      = 16;
	localparam int OUT_POS_W   = 32;
	localparam int HALF_W      = 32;
	localparam int RAMP_W      = 24;
	localparam int INC_W       = 16;
	localparam int EDGES_W     = STEPS_W + 1;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// divider: 32-bit dividend, divisor twice the rate
	localparam int DIV_STEPS = HALF_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DIVISOR_W = RATE_W + 1;

	// reset values
	localparam logic [31:0]        RESET_POSITION  = 32'd100000;
	localparam logic [31:0]        RESET_CLOCK_HZ  = 32'd72000000;
	localparam logic [RAMP_W-1:0]  RESET_RAMP_PER  = 24'd72000;
	localparam logic [INC_W-1:0]   RESET_RAMP_INC  = 16'd8;
	localparam logic [31:0]        RESET_MAX_POS   = 32'd1000000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_RATE  = 3'd2,
		CMD_DIR   = 3'd3,
		CMD_ZERO  = 3'd4,
		CMD_STOP  = 3'd5
	} cmd_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOCK_RATE = 2'd0,
		CFG_RAMP_PER   = 2'd1,
		CFG_RAMP_INC   = 2'd2,
		CFG_MAX_POS    = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DLOAD,
		ST_DWAIT,
		ST_POST,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic div_load;
		logic post;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/sprpg_ctrl.sv
module sprpg_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  sprpg_pkg::dp_status_t   status,
	output sprpg_pkg::ctrl_cmd_t    cmd
);

	sprpg_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sprpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			sprpg_pkg::ST_IDLE: begin
				cmd.accept = 1'b1;
				if (in_valid) begin
					state_nxt = sprpg_pkg::ST_EXEC;
				end
			end
			sprpg_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nxt = status.need_div ? sprpg_pkg::ST_DLOAD : sprpg_pkg::ST_EMIT;
			end
			sprpg_pkg::ST_DLOAD: begin
				cmd.div_load = 1'b1;
				state_nxt = sprpg_pkg::ST_DWAIT;
			end
			sprpg_pkg::ST_DWAIT: begin
				if (!status.div_busy) begin
					state_nxt = sprpg_pkg::ST_POST;
				end
			end
			sprpg_pkg::ST_POST: begin
				cmd.post = 1'b1;
				state_nxt = sprpg_pkg::ST_EMIT;
			end
			sprpg_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = sprpg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sprpg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/sprpg_div.sv
module sprpg_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [sprpg_pkg::HALF_W-1:0]         dividend,
	input  logic [sprpg_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                 busy,
	output logic [sprpg_pkg::HALF_W-1:0]         quotient
);

	logic                                run_q;
	logic [sprpg_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [sprpg_pkg::DIVISOR_W-1:0]     rem_q;
	logic [sprpg_pkg::HALF_W-1:0]        quo_q;
	logic [sprpg_pkg::DIVISOR_W-1:0]     dsr_q;
	logic [sprpg_pkg::DIVISOR_W:0]       trial;
	logic [sprpg_pkg::DIVISOR_W:0]       diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[sprpg_pkg::HALF_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == sprpg_pkg::DIV_CNT_W'(sprpg_pkg::DIV_STEPS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[sprpg_pkg::DIVISOR_W]) begin
				rem_q <= diff[sprpg_pkg::DIVISOR_W-1:0];
				quo_q <= {quo_q[sprpg_pkg::HALF_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[sprpg_pkg::DIVISOR_W-1:0];
				quo_q <= {quo_q[sprpg_pkg::HALF_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = run_q;
	assign quotient = quo_q;

endmodule

>>> rtl/sprpg_dp.sv
module sprpg_dp #(
	parameter int POS_BITS  = sprpg_pkg::POS_BITS_DEF,
	parameter int RATE_BITS = sprpg_pkg::RATE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sprpg_pkg::ctrl_cmd_t                   cmd,
	output sprpg_pkg::dp_status_t                  status,
	input  logic                                   in_valid,
	input  logic [sprpg_pkg::IN_TDATA_W-1:0]       in_data,
	input  logic [sprpg_pkg::CMD_W-1:0]            in_cmd,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [sprpg_pkg::OUT_TDATA_W-1:0]      out_data,
	output logic                                   out_last,
	input  logic                                   cfg_we,
	input  logic [sprpg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sprpg_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int RW = sprpg_pkg::RATE_W;
	localparam logic [RW-1:0] RATE_MAX =
		(RATE_BITS >= RW) ? {RW{1'b1}} : RW'((64'd1 << RATE_BITS) - 64'd1);

	// configuration
	logic [31:0]                    clock_hz_q;
	logic [sprpg_pkg::RAMP_W-1:0]   ramp_per_q;
	logic [sprpg_pkg::INC_W-1:0]    ramp_inc_q;
	logic [31:0]                    max_pos_q;

	// axis state
	logic [POS_BITS-1:0]            pos_q;
	logic [RW-1:0]                  cur_rate_q;
	logic [RW-1:0]                  tgt_rate_q;
	logic                           dir_q;
	logic                           stop_q;
	logic [sprpg_pkg::EDGES_W-1:0]  edges_q;
	logic [sprpg_pkg::HALF_W-1:0]   half_q;
	logic [sprpg_pkg::HALF_W-1:0]   edge_tmr_q;
	logic [sprpg_pkg::RAMP_W-1:0]   ramp_tmr_q;
	logic                           ramp_act_q;
	logic                           run_q;
	logic                           pin_q;

	// per-item flags
	logic                           done_q;
	logic                           lim_q;
	logic                           start_q;

	// latched item
	logic [sprpg_pkg::CMD_W-1:0]    cmd_q;
	logic [sprpg_pkg::STEPS_W-1:0]  steps_q;
	logic [RW-1:0]                  rate_q;
	logic                           instant_q;
	logic                           dirv_q;
	logic                           stopv_q;

	logic                           out_valid_q;
	logic [sprpg_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                           out_last_q;

	logic [sprpg_pkg::HALF_W-1:0]   et_dec;
	logic [sprpg_pkg::RAMP_W-1:0]   rt_dec;
	logic [sprpg_pkg::RAMP_W-1:0]   ramp_reload;
	logic                           expire;
	logic                           maxed;
	logic                           can_step;
	logic                           ramp_fire;
	logic                           start_go;
	logic [RW:0]                    rate_sum;
	logic [RW-1:0]                  rate_up;
	logic [RW-1:0]                  rate_dn;
	logic [RW-1:0]                  rate_sat;
	logic                           div_busy;
	logic [sprpg_pkg::HALF_W-1:0]   quot;
	logic [sprpg_pkg::HALF_W-1:0]   half_new;

	sprpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (clock_hz_q),
		.divisor  ({cur_rate_q, 1'b0}),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign et_dec      = (edge_tmr_q != '0) ? edge_tmr_q - 1'b1 : '0;
	assign rt_dec      = (ramp_tmr_q != '0) ? ramp_tmr_q - 1'b1 : '0;
	assign ramp_reload = (ramp_per_q == '0) ? sprpg_pkg::RAMP_W'(1) : ramp_per_q;
	assign expire      = run_q && (et_dec == '0);
	assign maxed       = dir_q ? (pos_q == '0) : (pos_q == max_pos_q[POS_BITS-1:0]);
	assign can_step    = (edges_q != '0) && !(stop_q || maxed);
	assign ramp_fire   = ramp_act_q && (rt_dec == '0);
	assign start_go    = (steps_q != '0) && !run_q;

	// ramp toward target, clamped at target
	assign rate_sum = {1'b0, cur_rate_q} + {1'b0, ramp_inc_q};
	assign rate_up  = (rate_sum > {1'b0, tgt_rate_q}) ? tgt_rate_q : rate_sum[RW-1:0];
	assign rate_dn  = ((cur_rate_q - tgt_rate_q) > ramp_inc_q) ?
		cur_rate_q - ramp_inc_q : tgt_rate_q;

	assign rate_sat = (rate_q > RATE_MAX) ? RATE_MAX : rate_q;
	assign half_new = (cur_rate_q == '0) ? '0 : quot;

	assign status.need_div = ((cmd_q == sprpg_pkg::CMD_TICK) && ramp_fire) ||
		((cmd_q == sprpg_pkg::CMD_START) && start_go);
	assign status.div_busy = div_busy;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept && in_valid) begin
			cmd_q     <= in_cmd;
			steps_q   <= in_data[31:0];
			rate_q    <= in_data[47:32];
			instant_q <= in_data[48];
			dirv_q    <= in_data[49];
			stopv_q   <= in_data[50];
		end
		if (cmd.emit) begin
			out_data_q <= {4'b0, cur_rate_q, sprpg_pkg::OUT_POS_W'(pos_q),
				done_q && lim_q, run_q, dir_q, pin_q};
			out_last_q <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= sprpg_pkg::RESET_CLOCK_HZ;
			ramp_per_q  <= sprpg_pkg::RESET_RAMP_PER;
			ramp_inc_q  <= sprpg_pkg::RESET_RAMP_INC;
			max_pos_q   <= sprpg_pkg::RESET_MAX_POS;
			pos_q       <= sprpg_pkg::RESET_POSITION[POS_BITS-1:0];
			cur_rate_q  <= '0;
			tgt_rate_q  <= '0;
			dir_q       <= 1'b0;
			stop_q      <= 1'b0;
			edges_q     <= '0;
			half_q      <= '0;
			edge_tmr_q  <= '0;
			ramp_tmr_q  <= '0;
			ramp_act_q  <= 1'b0;
			run_q       <= 1'b0;
			pin_q       <= 1'b0;
			done_q      <= 1'b0;
			lim_q       <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sprpg_pkg::CFG_CLOCK_RATE: clock_hz_q <= cfg_data;
					sprpg_pkg::CFG_RAMP_PER:   ramp_per_q <= cfg_data[sprpg_pkg::RAMP_W-1:0];
					sprpg_pkg::CFG_RAMP_INC:   ramp_inc_q <= cfg_data[sprpg_pkg::INC_W-1:0];
					sprpg_pkg::CFG_MAX_POS:    max_pos_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if (cmd.accept && in_valid) begin
				done_q  <= 1'b0;
				lim_q   <= 1'b0;
				start_q <= 1'b0;
			end

			if (cmd.exec) begin
				unique case (cmd_q)
					sprpg_pkg::CMD_TICK: begin
						// edge timer first, then ramp timer
						if (run_q) begin
							edge_tmr_q <= et_dec;
							if (expire) begin
								pos_q <= dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
								if (can_step) begin
									pin_q   <= !pin_q;
									edges_q <= edges_q - 1'b1;
									if (half_q == '0) begin
										run_q  <= 1'b0;
										done_q <= 1'b1;
									end else begin
										edge_tmr_q <= half_q;
									end
								end else begin
									run_q  <= 1'b0;
									done_q <= 1'b1;
									lim_q  <= maxed;
								end
							end
						end
						if (ramp_act_q) begin
							if (rt_dec == '0) begin
								ramp_tmr_q <= ramp_reload;
								if (cur_rate_q < tgt_rate_q) begin
									cur_rate_q <= rate_up;
								end else if (tgt_rate_q < cur_rate_q) begin
									cur_rate_q <= rate_dn;
								end else begin
									ramp_act_q <= 1'b0;
								end
							end else begin
								ramp_tmr_q <= rt_dec;
							end
						end
					end
					sprpg_pkg::CMD_START: begin
						if (start_go) begin
							ramp_act_q <= 1'b1;
							ramp_tmr_q <= ramp_reload;
							edges_q    <= {steps_q, 1'b0} - 1'b1;
							start_q    <= 1'b1;
						end
					end
					sprpg_pkg::CMD_RATE: begin
						tgt_rate_q <= rate_sat;
						if (instant_q) begin
							cur_rate_q <= rate_sat;
						end
					end
					sprpg_pkg::CMD_DIR:  dir_q  <= dirv_q;
					sprpg_pkg::CMD_ZERO: pos_q  <= '0;
					sprpg_pkg::CMD_STOP: stop_q <= stopv_q;
					default: begin
					end
				endcase
			end

			if (cmd.post) begin
				half_q <= half_new;
				if (start_q) begin
					if (half_new == '0) begin
						done_q <= 1'b1;
					end else begin
						edge_tmr_q <= half_new;
						run_q      <= 1'b1;
					end
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/stepper_ramp_pulse_generator.sv
// step-pulse generator for one stepper axis with a linear rate ramp. every
// transfer on the slave side is a command or a time tick, and every one gives
// exactly one result transfer on the master side with the step and direction
// pin levels, run status, position and current rate. a tick that hits a ramp
// update, or a start command that begins a run, recomputes the half-period
// interval clock_rate_hz/(2*rate) in a bit-serial divider before its result
// is delivered; all other items skip the divider. the next item is taken
// while a result still waits in the output register. configuration writes
// land at once and are not held off, so they belong in gaps with no transfer
// in flight.
module stepper_ramp_pulse_generator #(
	parameter int POS_BITS  = sprpg_pkg::POS_BITS_DEF,
	parameter int RATE_BITS = sprpg_pkg::RATE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// command / tick stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// step_count[31:0], rate_value[47:32], rate_instant[48], dir_value[49],
	// stop_value[50], zero fill
	input  logic [sprpg_pkg::IN_TDATA_W-1:0]       s_tdata,
	// cmd[2:0]
	input  logic [sprpg_pkg::CMD_W-1:0]            s_tuser,

	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// step_level[0], dir_level[1], busy_res[2], limit_hit[3], position[35:4],
	// rate_now[51:36], zero fill
	output logic [sprpg_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// done_pulse: the run ended on this item
	output logic                                   m_tlast,

	// configuration write port
	input  logic                                   cfg_we,
	input  logic [sprpg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sprpg_pkg::CFG_DATA_W-1:0]       cfg_data
);

	sprpg_pkg::ctrl_cmd_t  cmd;
	sprpg_pkg::dp_status_t status;

	// sequencer: accept, execute, optional divide, finish, deliver
	sprpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	// axis state, timers, ramp, divider and output register
	sprpg_dp #(
		.POS_BITS  (POS_BITS),
		.RATE_BITS (RATE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.in_cmd    (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// input is taken only between items
	assign s_tready = cmd.accept;

endmodule

>>> rtl/sprpg_chk.sv
module sprpg_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [sprpg_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                                m_tlast
);

	// a limit stop is always the end of a run
	a_limit_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tlast)
		else $error("limit_hit without done_pulse");

	// a finished run is no longer busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[2])
		else $error("done_pulse while busy");

	// one item at a time: input closes after each transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken back to back");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind stepper_ramp_pulse_generator sprpg_chk u_sprpg_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> bench/step_axis_checker.sv
// watches the command, result and register channels, runs its own copy of the
// axis state and compares every result transfer with the oldest prediction
module step_axis_checker
	import sprpg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [CMD_W-1:0]       s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     pending,
	output logic                   run_busy,
	output int                     results_seen,
	output int                     runs_ended,
	output int                     limit_ends
);

	typedef struct packed {
		logic        step_lvl;
		logic        dir_lvl;
		logic        busy;
		logic        done;
		logic        at_limit;
		logic [31:0] pos;
		logic [15:0] rate;
	} axis_result_t;

	// register copies
	logic [31:0]       hz_cfg;
	logic [RAMP_W-1:0] per_cfg;
	logic [INC_W-1:0]  inc_cfg;
	logic [31:0]       maxpos_cfg;

	// axis state
	logic [31:0]        pos;
	logic [15:0]        cur_rate;
	logic [15:0]        tgt_rate;
	logic               dir_rev;
	logic               stop_on;
	logic [EDGES_W-1:0] edges_left;
	logic [31:0]        half_iv;
	logic [31:0]        edge_timer;
	logic [RAMP_W-1:0]  ramp_timer;
	logic               ramp_on;
	logic               run_on;
	logic               pin;

	axis_result_t due_results[$];

	function automatic logic [31:0] half_period_of(input logic [15:0] r);
		logic [63:0] q;
		if (r == 16'd0)
			return 32'd0;
		q = {32'd0, hz_cfg} / {47'd0, r, 1'b0};
		return q[31:0];
	endfunction

	function automatic logic [RAMP_W-1:0] ramp_reload();
		return (per_cfg == '0) ? RAMP_W'(1) : per_cfg;
	endfunction

	function automatic void ramp_step();
		logic [16:0] sum;
		if (cur_rate < tgt_rate) begin
			sum = {1'b0, cur_rate} + {1'b0, inc_cfg};
			cur_rate = (sum > {1'b0, tgt_rate}) ? tgt_rate : sum[15:0];
		end else if (tgt_rate < cur_rate) begin
			cur_rate = ((cur_rate - tgt_rate) > inc_cfg) ? cur_rate - inc_cfg : tgt_rate;
		end else begin
			ramp_on = 1'b0;
		end
		half_iv = half_period_of(cur_rate);
	endfunction

	// half-period expiry; returns 1 when the run ends
	function automatic logic edge_fire(output logic lim);
		logic ended;
		logic held;
		ended = 1'b0;
		lim = 1'b0;
		held = dir_rev ? (pos == 32'd0) : (pos == maxpos_cfg);
		if (edges_left != '0 && !(stop_on || held)) begin
			pin = ~pin;
			edges_left = edges_left - 1'b1;
			if (half_iv == 32'd0)
				ended = 1'b1;
			else
				edge_timer = half_iv;
		end else begin
			ended = 1'b1;
			lim = held;
		end
		pos = dir_rev ? pos - 32'd1 : pos + 32'd1;
		if (ended)
			run_on = 1'b0;
		return ended;
	endfunction

	function automatic axis_result_t axis_next(input logic [CMD_W-1:0] cmd,
			input logic [IN_TDATA_W-1:0] d);
		logic done;
		logic lim;
		axis_result_t r;
		done = 1'b0;
		lim = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (run_on) begin
					if (edge_timer != 32'd0)
						edge_timer = edge_timer - 32'd1;
					if (edge_timer == 32'd0)
						done = edge_fire(lim);
				end
				if (ramp_on) begin
					if (ramp_timer != '0)
						ramp_timer = ramp_timer - 1'b1;
					if (ramp_timer == '0) begin
						ramp_timer = ramp_reload();
						ramp_step();
					end
				end
			end
			CMD_START: begin
				if (d[31:0] != 32'd0 && !run_on) begin
					ramp_on = 1'b1;
					ramp_timer = ramp_reload();
					edges_left = {d[31:0], 1'b0} - 33'd1;
					half_iv = half_period_of(cur_rate);
					if (half_iv == 32'd0) begin
						done = 1'b1;
					end else begin
						edge_timer = half_iv;
						run_on = 1'b1;
					end
				end
			end
			CMD_RATE: begin
				tgt_rate = d[47:32];
				if (d[48])
					cur_rate = d[47:32];
			end
			CMD_DIR:  dir_rev = d[49];
			CMD_ZERO: pos = 32'd0;
			CMD_STOP: stop_on = d[50];
			default: ;
		endcase
		r.step_lvl = pin;
		r.dir_lvl  = dir_rev;
		r.busy     = run_on;
		r.done     = done;
		r.at_limit = done && lim;
		r.pos      = pos;
		r.rate     = cur_rate;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at result %0d: expected %h, got %h",
				what, results_seen, want, seen);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		axis_result_t want;
		axis_result_t got;
		if (!arst_n) begin
			hz_cfg     = RESET_CLOCK_HZ;
			per_cfg    = RESET_RAMP_PER;
			inc_cfg    = RESET_RAMP_INC;
			maxpos_cfg = RESET_MAX_POS;
			pos        = RESET_POSITION;
			cur_rate   = '0;
			tgt_rate   = '0;
			dir_rev    = 1'b0;
			stop_on    = 1'b0;
			edges_left = '0;
			half_iv    = '0;
			edge_timer = '0;
			ramp_timer = '0;
			ramp_on    = 1'b0;
			run_on     = 1'b0;
			pin        = 1'b0;
			due_results.delete();
			mismatches   = 0;
			results_seen = 0;
			runs_ended   = 0;
			limit_ends   = 0;
			pending  <= 0;
			run_busy <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLOCK_RATE: hz_cfg = cfg_data;
					CFG_RAMP_PER:   per_cfg = cfg_data[RAMP_W-1:0];
					CFG_RAMP_INC:   inc_cfg = cfg_data[INC_W-1:0];
					CFG_MAX_POS:    maxpos_cfg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.step_lvl = m_tdata[0];
				got.dir_lvl  = m_tdata[1];
				got.busy     = m_tdata[2];
				got.at_limit = m_tdata[3];
				got.pos      = m_tdata[35:4];
				got.rate     = m_tdata[51:36];
				got.done     = m_tlast;
				results_seen++;
				if (got.done)
					runs_ended++;
				if (got.at_limit)
					limit_ends++;
				if (due_results.size() == 0) begin
					note_mismatch("result with nothing outstanding", 32'd0, 32'd1);
				end else begin
					want = due_results.pop_front();
					if (got.step_lvl !== want.step_lvl)
						note_mismatch("step_level", want.step_lvl, got.step_lvl);
					if (got.dir_lvl !== want.dir_lvl)
						note_mismatch("dir_level", want.dir_lvl, got.dir_lvl);
					if (got.busy !== want.busy)
						note_mismatch("busy", want.busy, got.busy);
					if (got.done !== want.done)
						note_mismatch("done_pulse", want.done, got.done);
					if (got.at_limit !== want.at_limit)
						note_mismatch("limit_hit", want.at_limit, got.at_limit);
					if (got.pos !== want.pos)
						note_mismatch("position", want.pos, got.pos);
					if (got.rate !== want.rate)
						note_mismatch("rate_now", want.rate, got.rate);
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(axis_next(s_tuser, s_tdata));
			pending  <= due_results.size();
			run_busy <= run_on;
		end
	end

endmodule

>>> bench/tb_top.sv
// top of the bench: clock and reset, command/tick stimulus, result sink and
// the verdict. the comparison of results lives in step_axis_checker
module tb_top;
	import sprpg_pkg::*;

	// cmd codes the block leaves unused
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

	// run ceiling in clock cycles, far above the slowest legal run
	localparam int CYCLE_LIMIT = 1500000;
	// length of the deliberate receiver hold-off
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;

	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   mismatches;
	int   pending;
	logic run_busy;
	int   results_seen;
	int   runs_ended;
	int   limit_ends;

	int          n_items = 0;
	int          n_settings = 0;
	int          cycles = 0;
	logic [31:0] cur_hz = RESET_CLOCK_HZ;
	// quiet: no idling on either side (last part of the run)
	bit          quiet = 1'b0;
	// long_hold: request to the sink for one long hold-off
	bit          long_hold = 1'b0;

	always #1 clk = ~clk;

	stepper_ramp_pulse_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	step_axis_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.run_busy     (run_busy),
		.results_seen (results_seen),
		.runs_ended   (runs_ended),
		.limit_ends   (limit_ends)
	);

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("stepper_ramp_pulse_generator regression: fail");
			$finish;
		end
	end

	// result sink: random ready bursts, one long hold-off on request,
	// ready held high once the run goes quiet
	initial begin : sink
		m_tready = 1'b0;
		forever begin
			if (long_hold) begin
				// hold-off counted here while the sender keeps offering, so the
				// block fills up and drops s_tready
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// one command/tick transfer; fields a command does not use carry whatever
	// the caller passes, usually random
	task automatic send(input logic [CMD_W-1:0] cmd, input logic [31:0] steps,
			input logic [15:0] rate, input logic inst, input logic dir_v,
			input logic stp);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		// zero fill, stop_value, dir_value, rate_instant, rate_value, step_count
		s_tdata  <= {5'd0, stp, dir_v, inst, rate, steps};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
	endtask

	// time tick with random payload, which the block must ignore
	task automatic tick();
		send(CMD_TICK, $urandom, $urandom, $urandom_range(0, 1),
			$urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	// sender pauses until every outstanding result has been seen
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// register write; the write lands at the next rising edge
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// full register set, only ever called with the block drained
	task automatic set_regs(input logic [31:0] hz, input logic [23:0] per,
			input logic [15:0] inc, input logic [31:0] maxp);
		write_reg(CFG_CLOCK_RATE, hz);
		write_reg(CFG_RAMP_PER, {8'd0, per});
		write_reg(CFG_RAMP_INC, {16'd0, inc});
		write_reg(CFG_MAX_POS, maxp);
		cfg_we <= 1'b0;
		cur_hz = hz;
		n_settings++;
	endtask

	// end any run in progress: raise stop, tick until the axis goes idle,
	// then clear stop again
	task automatic park_axis();
		int guard;
		send(CMD_STOP, $urandom, $urandom, $urandom_range(0, 1),
			$urandom_range(0, 1), 1'b1);
		drain();
		guard = 0;
		while (run_busy && guard < 250) begin
			repeat (8) tick();
			drain();
			guard++;
		end
		send(CMD_STOP, $urandom, $urandom, $urandom_range(0, 1),
			$urandom_range(0, 1), 1'b0);
		drain();
	endtask

	// noise inside a move: any command, the spare codes too. with the
	// slow clock a start is replaced by a tick, since a run there would
	// never reach its first edge
	task automatic stray_item(input bit slow);
		case ($urandom_range(0, 6))
			0: send(CMD_STOP, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			1: send(CMD_DIR, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			2: send(CMD_RATE, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			3: begin
				if (slow)
					tick();
				else
					send(CMD_START, $urandom_range(0, 3), $urandom,
						$urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1));
			end
			4: send(CMD_ZERO, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			5: send(CMD_SPARE_A, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			default: send(CMD_SPARE_B, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
		endcase
	endtask

	// one well-formed move: optional stop clear, direction and zeroing, a rate
	// that gives a half period of a few ticks, a start, then a train of ticks
	// with occasional noise mixed in
	task automatic move_sequence(input bit slow);
		int          k;
		int          n_ticks;
		logic [31:0] want;
		logic [15:0] r;
		k = $urandom_range(1, 6);
		want = cur_hz / (2 * k);
		r = (want > 32'hFFFF || $urandom_range(0, 7) == 0) ? 16'($urandom) : want[15:0];
		if ($urandom_range(0, 1))
			send(CMD_STOP, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), 1'b0);
		if ($urandom_range(0, 2) == 0)
			send(CMD_DIR, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
		if ($urandom_range(0, 5) == 0)
			send(CMD_ZERO, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
		if (slow) begin
			// rate forced to zero so the start ends at once, then ramp upward
			send(CMD_RATE, $urandom, 16'd0, 1'b1, $urandom_range(0, 1),
				$urandom_range(0, 1));
			send(CMD_START, $urandom, $urandom, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			send(CMD_RATE, $urandom, r, 1'b0, $urandom_range(0, 1),
				$urandom_range(0, 1));
		end else begin
			send(CMD_RATE, $urandom, r, $urandom_range(0, 3) != 0,
				$urandom_range(0, 1), $urandom_range(0, 1));
			send(CMD_START, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 6),
				$urandom, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1));
		end
		n_ticks = $urandom_range(4, 40);
		repeat (n_ticks) begin
			if ($urandom_range(0, 9) == 0)
				stray_item(slow);
			else
				tick();
		end
	endtask

	// one register setting with random moves until the item budget is used
	task automatic run_phase(input logic [31:0] hz, input logic [23:0] per,
			input logic [15:0] inc, input logic [31:0] maxp, input bit slow,
			input int budget, input bit with_hold);
		int stop_at;
		drain();
		set_regs(hz, per, inc, maxp);
		if (with_hold)
			long_hold = 1'b1;
		stop_at = n_items + budget;
		while (n_items < stop_at)
			move_sequence(slow);
		park_axis();
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_TICK;
		cfg_we    = 1'b0;
		cfg_index = CFG_CLOCK_RATE;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: the start sees rate zero and ends at once,
		// the ramp then runs on a one-millisecond period
		n_settings++;
		tick();
		send(CMD_RATE, 32'd0, 16'd100, 1'b0, 1'b0, 1'b0);
		send(CMD_START, 32'd3, 16'd0, 1'b0, 1'b0, 1'b0);
		tick();
		drain();

		// directed part: half period of one tick, forward limit six half-steps
		// above the reset position
		set_regs(32'd240, 24'd2, 16'd7, 32'd100006);
		send(CMD_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send(CMD_SPARE_B, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_RATE, 32'd0, 16'd120, 1'b1, 1'b0, 1'b0);
		send(CMD_DIR, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		// zero step count does nothing
		send(CMD_START, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_START, 32'd2, 16'd0, 1'b0, 1'b0, 1'b0);
		// start while busy is ignored
		send(CMD_START, 32'd1, 16'd0, 1'b0, 1'b0, 1'b0);
		// edges run out
		repeat (4) tick();
		// run into the forward limit
		send(CMD_START, 32'd4, 16'd0, 1'b0, 1'b0, 1'b0);
		repeat (3) tick();
		// reverse from zero: limit at once, position wraps below zero
		send(CMD_ZERO, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		send(CMD_DIR, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0);
		send(CMD_START, 32'd3, 16'd0, 1'b0, 1'b1, 1'b0);
		tick();
		// stop flag ends the run on the next expiry
		send(CMD_STOP, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
		send(CMD_START, 32'd2, 16'd0, 1'b0, 1'b0, 1'b1);
		tick();
		send(CMD_STOP, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		// zero rate gives a zero interval, the run ends as it starts
		send(CMD_RATE, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		send(CMD_START, 32'd1, 16'd0, 1'b0, 1'b0, 1'b0);
		// ramp toward the top rate, then the longest step count
		send(CMD_RATE, 32'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		repeat (3) tick();
		send(CMD_START, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, 1'b0);
		repeat (2) tick();
		drain();
		park_axis();

		// random part across several register settings; the first phase
		// carries the long receiver hold-off
		run_phase(32'd600, 24'd4, 16'd3, 32'd100040, 1'b0, 36, 1'b1);
		// smallest clock, shortest period, largest increment, limit at zero
		run_phase(32'd1, 24'd1, 16'hFFFF, 32'd0, 1'b0, 30, 1'b0);
		// longest ramp period, smallest increment, limit at the top
		run_phase(32'd2000, 24'hFF_FFFF, 16'd1, 32'hFFFF_FFFF, 1'b0, 36, 1'b0);
		// largest clock: every start is made at rate zero
		run_phase(32'hFFFF_FFFF, 24'd1, 16'hFFFF, 32'd100, 1'b1, 30, 1'b0);
		run_phase(32'd300, 24'd2, 16'd1, 32'd5, 1'b0, 36, 1'b0);
		run_phase(32'd900, 24'd1, 16'd50, $urandom, 1'b0, 36, 1'b0);
		// last part with no idling on either side
		quiet = 1'b1;
		run_phase(32'd480, 24'd3, 16'd20, 32'd100200, 1'b0, 36, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d command and tick transfers over %0d register settings",
			n_items, n_settings);
		$display("%0d results checked, %0d runs ended, %0d of them at a position limit",
			results_seen, runs_ended, limit_ends);
		if (mismatches == 0 && pending == 0) begin
			$display("stepper_ramp_pulse_generator regression: pass");
		end else begin
			$display("stepper_ramp_pulse_generator regression: fail");
		end
		$finish;
	end

endmodule
